// ===== sv/csoe_pkg.sv =====
package csoe_pkg;

	// Fixed field widths
	localparam int ADC_W   = 12;
	localparam int MA_W    = 21;
	localparam int POWER_W = 28;
	localparam int FILT_W  = 37;
	localparam int FRAC_W  = 16;
	localparam int ALPHA_W = 17;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Defaults for the top-level parameters
	localparam int SAMPLE_COUNT_DEF = 32;
	localparam int ADC_BITS_DEF     = 12;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Numeric limits
	localparam int MA_MAX = 1048575;
	localparam int MA_MIN = -1048576;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	// Command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FAIL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_VOLTS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MARGIN   = 3'd4;

	// Register reset values
	localparam logic [11:0] ZERO_CODE_RST    = 12'd2048;
	localparam logic [15:0] CURRENT_GAIN_RST = 16'd2063;
	localparam logic [16:0] EMA_ALPHA_RST    = 17'd6554;
	localparam logic [7:0]  SUPPLY_VOLTS_RST = 8'd24;
	localparam logic [11:0] SAT_MARGIN_RST   = 12'd10;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_FAIL,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ADC_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [11:0] zero_code;
		logic [15:0] current_gain;
		logic [16:0] ema_alpha;
		logic [7:0]  supply_volts;
		logic [11:0] saturation_margin;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RAW_MUL,
		ST_RAW_CLAMP,
		ST_EMA_DIFF,
		ST_EMA_LO,
		ST_EMA_HI,
		ST_EMA_SUM,
		ST_EMA_UPD,
		ST_MAG,
		ST_POWER,
		ST_OUT
	} state_t;

endpackage

// ===== sv/csoe_front.sv =====
module csoe_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [csoe_pkg::CMD_W-1:0]    command,
	input  logic [csoe_pkg::ADC_W-1:0]    adc_sample,
	output logic                          q_valid,
	output csoe_pkg::item_t               q_item,
	input  logic                          q_pop
);
	import csoe_pkg::*;

	item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	op_t               op;
	logic              keep;
	logic              push;
	logic              pop;

	// Classify the command; the unused code is taken and dropped
	always_comb begin
		op   = OP_SAMPLE;
		keep = 1'b1;
		case (command)
			CMD_SAMPLE: op = OP_SAMPLE;
			CMD_FAIL:   op = OP_FAIL;
			CMD_CLEAR:  op = OP_CLEAR;
			default:    keep = 1'b0;
		endcase
	end

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (count_q != '0);
	assign q_item   = entries_q[rd_ptr_q];

	// Advance the queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store the classified beat
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q].op     <= op;
			entries_q[wr_ptr_q].sample <= adc_sample;
		end
	end

endmodule

// ===== sv/csoe_back.sv =====
module csoe_back #(
	parameter int SAMPLE_COUNT = csoe_pkg::SAMPLE_COUNT_DEF,
	parameter int ADC_BITS     = csoe_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  csoe_pkg::item_t                   q_item,
	output logic                              q_pop,
	input  csoe_pkg::cfg_t                    cfg,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [csoe_pkg::MA_W-1:0]  raw_current_ma,
	output logic signed [csoe_pkg::MA_W-1:0]  filtered_current_ma,
	output logic [csoe_pkg::MA_W-1:0]         abs_current_ma,
	output logic [csoe_pkg::POWER_W-1:0]      power_mw,
	output logic                              saturated
);
	import csoe_pkg::*;

	localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int SUM_W = ADC_W + $clog2(SAMPLE_COUNT);
	localparam int THR_W = ((ADC_BITS > ADC_W) ? ADC_BITS : ADC_W) + 2;
	localparam logic [THR_W-1:0] FULL_SCALE = THR_W'(2 ** ADC_BITS);
	localparam int DIFF_W = FILT_W + 1;
	localparam int HALF_W = DIFF_W / 2;
	localparam int TOT_W  = 55;
	// Reciprocal of the window length, exact for every sum that fits SUM_W
	localparam int DIV_SH  = SUM_W + $clog2(SAMPLE_COUNT);
	localparam int RECIP_W = SUM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SH) +
		64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

	state_t state_q, state_d;

	// Window and filter state
	logic [SUM_W-1:0]         sum_q;
	logic [ADC_W-1:0]         peak_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [FILT_W-1:0] fv_q;
	logic                     started_q;

	// Sequencer scratch
	logic [SUM_W-1:0]         dividend_q;
	logic [ADC_W-1:0]         avg_q;
	logic                     sat_q;
	logic signed [MA_W-1:0]   raw_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [39:0]       mul_q;
	logic [35:0]              lo_q;
	logic [38:0]              delta_q;
	logic [MA_W-1:0]          mag_q;
	logic                     out_valid_q;

	logic              load_out;
	logic              win_end;
	logic [SUM_W-1:0]  sum_nx;
	logic [ADC_W-1:0]  peak_nx;
	logic [2*SUM_W:0]  quot_prod;
	logic signed [12:0] zdiff;
	logic [ALPHA_W-1:0] alpha_c;
	logic signed [21:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [39:0] prod;
	logic signed [31:0] scaled;
	logic signed [MA_W-1:0] raw_c;
	logic [TOT_W-1:0]   total;
	logic signed [MA_W-1:0] filt;
	logic               sat_nx;

	// Window update for the beat at the head of the queue
	always_comb begin
		sum_nx  = sum_q;
		peak_nx = peak_q;
		if (q_item.op == OP_SAMPLE) begin
			sum_nx = sum_q + SUM_W'(q_item.sample);
			if (q_item.sample > peak_q)
				peak_nx = q_item.sample;
		end
	end

	assign win_end = (q_item.op != OP_CLEAR) && (cnt_q == CNT_W'(SAMPLE_COUNT - 1));
	assign sat_nx  = (THR_W'(peak_nx) + THR_W'(cfg.saturation_margin)) >= FULL_SCALE;

	// Window average by reciprocal multiply, and arithmetic helpers
	assign quot_prod = {{RECIP_W{1'b0}}, dividend_q} * {{SUM_W{1'b0}}, RECIP};
	assign zdiff   = {1'b0, avg_q} - {1'b0, cfg.zero_code};
	assign alpha_c = (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;
	assign scaled  = mul_q[39:8];
	assign total   = ({{(TOT_W-40){mul_q[39]}}, mul_q} << HALF_W) +
	                 {{(TOT_W-36){1'b0}}, lo_q};
	assign filt    = fv_q[FILT_W-1:FRAC_W];

	always_comb begin
		if (scaled > MA_MAX)
			raw_c = MA_W'(MA_MAX);
		else if (scaled < MA_MIN)
			raw_c = MA_W'(MA_MIN);
		else
			raw_c = scaled[MA_W-1:0];
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_RAW_MUL: begin
				mul_a = {{9{zdiff[12]}}, zdiff};
				mul_b = {2'b00, cfg.current_gain};
			end
			ST_EMA_LO: begin
				mul_a = {3'b000, diff_q[HALF_W-1:0]};
				mul_b = {1'b0, alpha_c};
			end
			ST_EMA_HI: begin
				mul_a = {{3{diff_q[DIFF_W-1]}}, diff_q[DIFF_W-1:HALF_W]};
				mul_b = {1'b0, alpha_c};
			end
			ST_POWER: begin
				mul_a = {1'b0, mag_q};
				mul_b = {10'b0, cfg.supply_volts};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (win_end)
						state_d = ST_DIV;
				end
			end
			ST_DIV:       state_d = ST_RAW_MUL;
			ST_RAW_MUL:   state_d = ST_RAW_CLAMP;
			ST_RAW_CLAMP: state_d = started_q ? ST_EMA_DIFF : ST_MAG;
			ST_EMA_DIFF:  state_d = ST_EMA_LO;
			ST_EMA_LO:    state_d = ST_EMA_HI;
			ST_EMA_HI:    state_d = ST_EMA_SUM;
			ST_EMA_SUM:   state_d = ST_EMA_UPD;
			ST_EMA_UPD:   state_d = ST_MAG;
			ST_MAG:       state_d = ST_POWER;
			ST_POWER:     state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Window, filter and output-valid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			peak_q      <= '0;
			cnt_q       <= '0;
			fv_q        <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.op == OP_CLEAR) begin
					sum_q     <= '0;
					peak_q    <= '0;
					cnt_q     <= '0;
					fv_q      <= '0;
					started_q <= 1'b0;
				end else if (win_end) begin
					sum_q  <= '0;
					peak_q <= '0;
					cnt_q  <= '0;
				end else begin
					sum_q  <= sum_nx;
					peak_q <= peak_nx;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			// Seed the filter from the first window
			if (state_q == ST_RAW_CLAMP && !started_q) begin
				fv_q      <= {raw_c, {FRAC_W{1'b0}}};
				started_q <= 1'b1;
			end
			if (state_q == ST_EMA_UPD)
				fv_q <= fv_q + delta_q[FILT_W-1:0];
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop && win_end) begin
					dividend_q <= sum_nx;
					sat_q      <= sat_nx;
				end
			end
			ST_DIV:       avg_q <= quot_prod[DIV_SH +: ADC_W];
			ST_RAW_MUL:   mul_q <= prod;
			ST_RAW_CLAMP: raw_q <= raw_c;
			ST_EMA_DIFF: begin
				diff_q <= {raw_c[MA_W-1], raw_q, {FRAC_W{1'b0}}} - {fv_q[FILT_W-1], fv_q};
			end
			ST_EMA_LO: mul_q <= prod;
			ST_EMA_HI: begin
				lo_q  <= mul_q[35:0];
				mul_q <= prod;
			end
			ST_EMA_SUM: delta_q <= total[TOT_W-1:FRAC_W];
			ST_MAG:     mag_q <= filt[MA_W-1] ? (~filt + 1'b1) : filt;
			ST_POWER:   mul_q <= prod;
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			raw_current_ma      <= raw_q;
			filtered_current_ma <= filt;
			abs_current_ma      <= mag_q;
			power_mw            <= mul_q[POWER_W-1:0];
			saturated           <= sat_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/current_sense_oversample_ema.sv =====
// Hall current sensor front end: every accepted beat is one ADC slot (valid
// sample, failed conversion, or a clear of window and filter). Beats go into a
// four-entry queue and the back end retires one slot per clock while idle, so
// samples are taken at one per cycle while the queue has room. After
// SAMPLE_COUNT slots the back end runs its result sequence: a reciprocal
// multiply for the window average, then the milliamp scaling, the filter
// update (skipped on the first window after reset or a clear, which seeds the
// filter), and magnitude, power and the output load; scaling, filter and power
// share one multiplier. During that sequence the queue keeps accepting until
// full. The result sits in an output register until taken. Registers are
// written through the cfg port, which is always ready; write them only while
// the block is idle.
module current_sense_oversample_ema #(
	parameter int SAMPLE_COUNT = csoe_pkg::SAMPLE_COUNT_DEF,
	parameter int ADC_BITS     = csoe_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [csoe_pkg::CMD_W-1:0]         command,
	input  logic [csoe_pkg::ADC_W-1:0]         adc_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [csoe_pkg::MA_W-1:0]   raw_current_ma,
	output logic signed [csoe_pkg::MA_W-1:0]   filtered_current_ma,
	output logic [csoe_pkg::MA_W-1:0]          abs_current_ma,
	output logic [csoe_pkg::POWER_W-1:0]       power_mw,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csoe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csoe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import csoe_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	assign cfg_ready = 1'b1;

	// Register file; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_code         <= ZERO_CODE_RST;
			cfg_q.current_gain      <= CURRENT_GAIN_RST;
			cfg_q.ema_alpha         <= EMA_ALPHA_RST;
			cfg_q.supply_volts      <= SUPPLY_VOLTS_RST;
			cfg_q.saturation_margin <= SAT_MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ZERO_CODE:    cfg_q.zero_code         <= cfg_data[11:0];
				REG_CURRENT_GAIN: cfg_q.current_gain      <= cfg_data[15:0];
				REG_EMA_ALPHA:    cfg_q.ema_alpha         <= cfg_data[16:0];
				REG_SUPPLY_VOLTS: cfg_q.supply_volts      <= cfg_data[7:0];
				REG_SAT_MARGIN:   cfg_q.saturation_margin <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	csoe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.adc_sample (adc_sample),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	csoe_back #(
		.SAMPLE_COUNT (SAMPLE_COUNT),
		.ADC_BITS     (ADC_BITS)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_valid             (q_valid),
		.q_item              (q_item),
		.q_pop               (q_pop),
		.cfg                 (cfg_q),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.raw_current_ma      (raw_current_ma),
		.filtered_current_ma (filtered_current_ma),
		.abs_current_ma      (abs_current_ma),
		.power_mw            (power_mw),
		.saturated           (saturated)
	);

endmodule

// ===== tb/csoe_result_checker.sv =====
module csoe_result_checker #(
	parameter int SAMPLE_COUNT = csoe_pkg::SAMPLE_COUNT_DEF,
	parameter int ADC_BITS     = csoe_pkg::ADC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [csoe_pkg::CMD_W-1:0]            command,
	input  logic [csoe_pkg::ADC_W-1:0]            adc_sample,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [csoe_pkg::MA_W-1:0]      raw_current_ma,
	input  logic signed [csoe_pkg::MA_W-1:0]      filtered_current_ma,
	input  logic [csoe_pkg::MA_W-1:0]             abs_current_ma,
	input  logic [csoe_pkg::POWER_W-1:0]          power_mw,
	input  logic                                  saturated,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [csoe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [csoe_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                    mismatches,
	output int                                    windows_pending,
	output int                                    windows_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import csoe_pkg::*;

	typedef struct packed {
		logic signed [MA_W-1:0] raw_ma;
		logic signed [MA_W-1:0] filt_ma;
		logic [MA_W-1:0]        mag_ma;
		logic [POWER_W-1:0]     power;
		logic                   sat;
	} window_result_t;

	// Shadow of the register file and of the window and filter state
	cfg_t               regs;
	logic [16:0]        win_sum;
	logic [ADC_W-1:0]   win_peak;
	int                 win_slots;
	longint             ema_q16;
	bit                 ema_seeded;
	window_result_t     expected_windows[$];

	function automatic void empty_window();
		win_sum = '0;
		win_peak = '0;
		win_slots = 0;
	endfunction

	// Absorb one slot; return 1 with the window result when the window closes
	function automatic bit take_slot(input logic [CMD_W-1:0] cmd, input logic [ADC_W-1:0] smp,
			output window_result_t res);
		longint avg;
		longint cur;
		longint thresh;
		longint wt;
		longint filt;
		longint mag;
		longint pwr;
		res = '0;
		if (cmd == CMD_CLEAR) begin
			empty_window();
			ema_q16 = 0;
			ema_seeded = 0;
			return 0;
		end
		// Drop the unused command code
		if (cmd != CMD_SAMPLE && cmd != CMD_FAIL)
			return 0;
		if (cmd == CMD_SAMPLE) begin
			win_sum += smp;
			if (smp > win_peak)
				win_peak = smp;
		end
		win_slots++;
		if (win_slots < SAMPLE_COUNT)
			return 0;

		// Average, offset and scale to milliamps with a floor shift, then clamp
		avg = longint'(win_sum) / SAMPLE_COUNT;
		cur = ((avg - longint'(regs.zero_code)) * longint'(regs.current_gain)) >>> 8;
		if (cur > MA_MAX)
			cur = MA_MAX;
		if (cur < MA_MIN)
			cur = MA_MIN;

		// Saturation threshold never goes below zero
		thresh = (longint'(1) << ADC_BITS) - longint'(regs.saturation_margin);
		if (thresh < 0)
			thresh = 0;
		res.sat = (longint'(win_peak) >= thresh);

		// Seed the filter on the first window, else blend with alpha capped at one
		if (!ema_seeded) begin
			ema_q16 = cur <<< FRAC_W;
			ema_seeded = 1;
		end else begin
			wt = (regs.ema_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(regs.ema_alpha);
			ema_q16 = (wt * (cur <<< FRAC_W) + (longint'(ALPHA_ONE) - wt) * ema_q16) >>> FRAC_W;
		end

		filt = ema_q16 >>> FRAC_W;
		mag = (filt < 0) ? -filt : filt;
		pwr = mag * longint'(regs.supply_volts);
		res.raw_ma = cur[MA_W-1:0];
		res.filt_ma = filt[MA_W-1:0];
		res.mag_ma = mag[MA_W-1:0];
		res.power = pwr[POWER_W-1:0];
		empty_window();
		return 1;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Track config writes, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin : track
		window_result_t res;
		window_result_t want;
		if (!arst_n) begin
			regs = '{zero_code: ZERO_CODE_RST, current_gain: CURRENT_GAIN_RST,
				ema_alpha: EMA_ALPHA_RST, supply_volts: SUPPLY_VOLTS_RST,
				saturation_margin: SAT_MARGIN_RST};
			empty_window();
			ema_q16 = 0;
			ema_seeded = 0;
			expected_windows.delete();
			windows_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ZERO_CODE:    regs.zero_code = cfg_data[11:0];
					REG_CURRENT_GAIN: regs.current_gain = cfg_data[15:0];
					REG_EMA_ALPHA:    regs.ema_alpha = cfg_data[16:0];
					REG_SUPPLY_VOLTS: regs.supply_volts = cfg_data[7:0];
					REG_SAT_MARGIN:   regs.saturation_margin = cfg_data[11:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (take_slot(command, adc_sample, res))
					expected_windows.push_back(res);
			end
			if (out_valid && !out_stall) begin
				windows_seen++;
				if (expected_windows.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with no window pending, raw %0d filtered %0d",
						$time, raw_current_ma, filtered_current_ma);
				end else begin
					want = expected_windows.pop_front();
					check_field("raw_current_ma", longint'(want.raw_ma), longint'(raw_current_ma));
					check_field("filtered_current_ma", longint'(want.filt_ma),
						longint'(filtered_current_ma));
					check_field("abs_current_ma", longint'(want.mag_ma), longint'(abs_current_ma));
					check_field("power_mw", longint'(want.power), longint'(power_mw));
					check_field("saturated", longint'(want.sat), longint'(saturated));
				end
			end
			windows_pending = expected_windows.size();
		end
	end

endmodule

// ===== tb/tb_current_sense_oversample_ema.sv =====
module tb_current_sense_oversample_ema;
	timeunit 1ns;
	timeprecision 1ps;

	import csoe_pkg::*;

	localparam int WINDOW_SLOTS    = 32;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int SETTLE_CYCLES   = 40;
	localparam int CYCLE_LIMIT     = 200000;
	localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	// Sample shapes for one window of random stimulus
	localparam int SHAPE_UNIFORM    = 0;
	localparam int SHAPE_NEAR_ZERO  = 1;
	localparam int SHAPE_FULL_SCALE = 2;
	localparam int SHAPE_FLOOR      = 3;
	localparam int SHAPE_NEAR_TOP   = 4;
	localparam int SHAPE_MOSTLY_BAD = 5;
	localparam int SHAPE_ALL_BAD    = 6;
	localparam int SHAPE_NOISY      = 7;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [CMD_W-1:0]          command;
	logic [ADC_W-1:0]          adc_sample;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [MA_W-1:0]    raw_current_ma;
	logic signed [MA_W-1:0]    filtered_current_ma;
	logic [MA_W-1:0]           abs_current_ma;
	logic [POWER_W-1:0]        power_mw;
	logic                      saturated;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	int mismatches;
	int windows_pending;
	int windows_seen;
	int slots_sent;
	int cycles;
	bit calm;
	int zero_now;

	current_sense_oversample_ema uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.raw_current_ma(raw_current_ma), .filtered_current_ma(filtered_current_ma),
		.abs_current_ma(abs_current_ma), .power_mw(power_mw), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	csoe_result_checker monitor (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.raw_current_ma(raw_current_ma), .filtered_current_ma(filtered_current_ma),
		.abs_current_ma(abs_current_ma), .power_mw(power_mw), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .windows_pending(windows_pending),
		.windows_seen(windows_seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stall the result side for a random count before each result beat
	initial begin : result_stall
		int hold;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (hold != 0) begin
				out_stall <= 1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Send one slot beat after a random gap, hold it until accepted
	task automatic send_slot(input logic [CMD_W-1:0] cmd, input logic [ADC_W-1:0] smp);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		adc_sample <= smp;
		do @(posedge clk); while (in_stall);
		slots_sent++;
	endtask

	// Drop valid, wait for every pending window and let the back end go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 0;
		while (windows_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_regs(input int zc, input int gain, input int alpha, input int volts,
			input int margin);
		write_reg(REG_ZERO_CODE, zc);
		write_reg(REG_CURRENT_GAIN, gain);
		write_reg(REG_EMA_ALPHA, alpha);
		write_reg(REG_SUPPLY_VOLTS, volts);
		write_reg(REG_SAT_MARGIN, margin);
		zero_now = zc;
	endtask

	// Mostly well-formed windows with a shaped sample set, plus noise beats
	task automatic run_random(input int phase);
		int shape;
		int r;
		int v;
		logic [CMD_W-1:0] cmd;
		logic [ADC_W-1:0] smp;
		calm = ($urandom_range(0, 3) == 0);
		send_slot(CMD_CLEAR, 12'($urandom));
		for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (k % WINDOW_SLOTS == 0) begin
				if (k == 0 && phase == 1)
					shape = SHAPE_ALL_BAD;
				else if (k == 0 && phase == 2)
					shape = SHAPE_FULL_SCALE;
				else
					shape = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0)
					calm = !calm;
			end
			case (shape)
				SHAPE_NEAR_ZERO: begin
					v = zero_now + $urandom_range(0, 128) - 64;
					if (v < 0)
						v = 0;
					if (v > 4095)
						v = 4095;
					smp = v[ADC_W-1:0];
				end
				SHAPE_FULL_SCALE: smp = 12'hFFF;
				SHAPE_FLOOR:      smp = 12'($urandom_range(0, 15));
				SHAPE_NEAR_TOP:   smp = 12'hFFF - 12'($urandom_range(0, 31));
				default:          smp = 12'($urandom_range(0, 4095));
			endcase
			r = $urandom_range(0, 99);
			if (shape == SHAPE_ALL_BAD)
				cmd = CMD_FAIL;
			else if (shape == SHAPE_FULL_SCALE)
				cmd = CMD_SAMPLE;
			else if (shape == SHAPE_MOSTLY_BAD)
				cmd = (r < 80) ? CMD_FAIL : CMD_SAMPLE;
			else if (shape == SHAPE_NOISY)
				cmd = (r < 6) ? CMD_CLEAR : (r < 14) ? CMD_UNUSED : (r < 25) ? CMD_FAIL : CMD_SAMPLE;
			else
				cmd = (r < 1) ? CMD_CLEAR : (r < 3) ? CMD_UNUSED : (r < 8) ? CMD_FAIL : CMD_SAMPLE;
			send_slot(cmd, smp);
		end
	endtask

	initial begin : stimulus
		arst_n = 0;
		in_valid = 0;
		command = CMD_SAMPLE;
		adc_sample = '0;
		cfg_valid = 0;
		cfg_index = REG_ZERO_CODE;
		cfg_data = '0;
		calm = 0;
		zero_now = ZERO_CODE_RST;
		repeat (4) @(negedge clk);
		arst_n <= 1;

		// Directed: ignored code, clears on empty and partial windows, field extremes
		send_slot(CMD_UNUSED, 12'hFFF);
		send_slot(CMD_CLEAR, 12'h000);
		send_slot(CMD_SAMPLE, 12'h000);
		send_slot(CMD_SAMPLE, 12'hFFF);
		send_slot(CMD_FAIL, 12'hFFF);
		send_slot(CMD_SAMPLE, 12'h800);
		send_slot(CMD_UNUSED, 12'h000);
		send_slot(CMD_SAMPLE, 12'h001);
		send_slot(CMD_CLEAR, 12'hFFF);
		send_slot(CMD_CLEAR, 12'h555);
		for (int k = 0; k < 12; k++)
			send_slot(CMD_SAMPLE, (k % 2) ? 12'hFFF : 12'h000);
		run_random(0);

		// Walk through register settings, extremes first
		for (int phase = 1; phase < PHASES; phase++) begin
			settle();
			case (phase)
				1: set_regs(0, 65535, 65536, 255, 0);
				2: set_regs(4095, 65535, 0, 255, 4095);
				3: set_regs(2048, 0, 131071, 0, 10);
				5: set_regs($urandom_range(0, 4095), $urandom_range(0, 65535), 1,
					$urandom_range(0, 255), $urandom_range(0, 4095));
				7: begin
					write_reg(REG_UNMAPPED, 131071);
					set_regs(ZERO_CODE_RST, CURRENT_GAIN_RST, EMA_ALPHA_RST,
						SUPPLY_VOLTS_RST, SAT_MARGIN_RST);
				end
				default: set_regs($urandom_range(0, 4095), $urandom_range(0, 65535),
					$urandom_range(0, 131071), $urandom_range(0, 255), $urandom_range(0, 4095));
			endcase
			run_random(phase);
		end

		settle();
		$display("Run covered %0d slot beats and %0d window results across %0d register settings.",
			slots_sent, windows_seen, PHASES);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
